// ----- sv/tgcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tgcw_pkg
// Shared types, constants and key decoding for the text grid cursor writer.
// ----------------------------------------------------------------------------
package tgcw_pkg;

  localparam int GRID_COLS  = 128;
  localparam int GRID_ROWS  = 64;
  localparam int CELL_COUNT = GRID_COLS * GRID_ROWS;
  localparam int IDX_W      = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(GRID_COLS);
  localparam int ROW_W      = $clog2(GRID_ROWS);
  localparam int STRIDE_W   = $clog2(GRID_COLS + 1);
  localparam int PROD_W     = ROW_W + STRIDE_W;

  localparam int POS_W  = 12;
  localparam int CODE_W = 8;
  localparam int REG_W  = 12;
  localparam int RIDX_W = 3;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  localparam logic [CODE_W-1:0] CHAR_MARK    = 8'h00;
  localparam logic [CODE_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CODE_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CODE_W-1:0] CHAR_FIRST   = 8'h21;
  localparam logic [CODE_W-1:0] CHAR_LAST    = 8'h7E;

  localparam logic [REG_W-1:0] RESET_LEFT   = 12'd0;
  localparam logic [REG_W-1:0] RESET_RIGHT  = 12'd128;
  localparam logic [REG_W-1:0] RESET_TOP    = 12'd0;
  localparam logic [REG_W-1:0] RESET_BOTTOM = 12'd64;

  localparam logic [RIDX_W-1:0] REG_WINDOW_LEFT   = 3'd0;
  localparam logic [RIDX_W-1:0] REG_WINDOW_RIGHT  = 3'd1;
  localparam logic [RIDX_W-1:0] REG_WINDOW_TOP    = 3'd2;
  localparam logic [RIDX_W-1:0] REG_WINDOW_BOTTOM = 3'd3;

  typedef enum logic [1:0] {
    KIND_KEY  = 2'd0,
    KIND_SET  = 2'd1,
    KIND_READ = 2'd2,
    KIND_NOP  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    KEY_NEWLINE,
    KEY_SPACE,
    KEY_MARK,
    KEY_PRINT,
    KEY_NONE
  } key_class_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP,
    ST_ACCESS,
    ST_DONE
  } ctl_state_t;

  typedef struct packed {
    logic [REG_W-1:0] left;
    logic [REG_W-1:0] right;
    logic [REG_W-1:0] top;
    logic [REG_W-1:0] bottom;
  } window_t;

  typedef struct packed {
    logic                in_window;
    logic [COL_W-1:0]    dc;
    logic [ROW_W-1:0]    dr;
    logic [STRIDE_W-1:0] stride;
  } map_t;

  typedef struct packed {
    logic              we_code;
    logic              we_mark;
    logic              rd;
    logic [IDX_W-1:0]  addr;
    logic [CODE_W-1:0] code;
    logic              mark;
  } mem_req_t;

  function automatic key_class_t key_class(input logic [CODE_W-1:0] code);
    priority if (code == CHAR_NEWLINE) return KEY_NEWLINE;
    else if (code == CHAR_SPACE) return KEY_SPACE;
    else if (code == CHAR_MARK) return KEY_MARK;
    else if (code >= CHAR_FIRST && code <= CHAR_LAST) return KEY_PRINT;
    else return KEY_NONE;
  endfunction

endpackage

// ----- sv/tgcw_cell_store.sv -----
// ----------------------------------------------------------------------------
// tgcw_cell_store
// Character code and highlight memories, one write and one registered read.
// ----------------------------------------------------------------------------
module tgcw_cell_store (
  input  logic                       clk,
  input  tgcw_pkg::mem_req_t         req,
  output logic [tgcw_pkg::CODE_W-1:0] rd_code,
  output logic                       rd_mark
);

  logic [tgcw_pkg::CODE_W-1:0] codes [tgcw_pkg::CELL_COUNT];
  logic                        marks [tgcw_pkg::CELL_COUNT];

  always_ff @(posedge clk) begin
    if (req.we_code) begin
      codes[req.addr] <= req.code;
    end
    if (req.we_mark) begin
      marks[req.addr] <= req.mark;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd) begin
      rd_code <= codes[req.addr];
      rd_mark <= marks[req.addr];
    end
  end

endmodule

// ----- sv/tgcw_cell_map.sv -----
// ----------------------------------------------------------------------------
// tgcw_cell_map
// Window test and store index: registered inside test, then row * stride + col.
// ----------------------------------------------------------------------------
module tgcw_cell_map (
  input  logic                        clk,
  input  logic                        load,
  input  tgcw_pkg::window_t           win,
  input  logic [tgcw_pkg::POS_W-1:0]  col,
  input  logic [tgcw_pkg::POS_W-1:0]  row,
  output tgcw_pkg::map_t              map,
  output logic [tgcw_pkg::IDX_W-1:0]  idx
);

  logic [tgcw_pkg::POS_W-1:0]    dc;
  logic [tgcw_pkg::POS_W-1:0]    dr;
  logic [tgcw_pkg::REG_W-1:0]    span;
  logic                          in_window;
  logic [tgcw_pkg::STRIDE_W-1:0] stride;
  logic [tgcw_pkg::PROD_W-1:0]   prod;

  always_comb begin
    dc   = col - win.left;
    dr   = row - win.top;
    span = win.right - win.left;
    in_window = (col >= win.left) && (col < win.right) &&
                (row >= win.top) && (row < win.bottom) &&
                ({1'b0, dc} < 13'(tgcw_pkg::GRID_COLS)) &&
                ({1'b0, dr} < 13'(tgcw_pkg::GRID_ROWS));
    if ({1'b0, span} < 13'(tgcw_pkg::GRID_COLS)) begin
      stride = tgcw_pkg::STRIDE_W'(span);
    end else begin
      stride = tgcw_pkg::STRIDE_W'(tgcw_pkg::GRID_COLS);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      map.in_window <= in_window;
      map.dc        <= dc[tgcw_pkg::COL_W-1:0];
      map.dr        <= dr[tgcw_pkg::ROW_W-1:0];
      map.stride    <= stride;
    end
  end

  assign prod = tgcw_pkg::PROD_W'(map.dr) * tgcw_pkg::PROD_W'(map.stride);
  assign idx  = tgcw_pkg::IDX_W'(prod + tgcw_pkg::PROD_W'(map.dc));

endmodule

// ----- sv/tgcw_cursor.sv -----
// ----------------------------------------------------------------------------
// tgcw_cursor
// Write cursor: newline, advance with saturation, and direct load.
// ----------------------------------------------------------------------------
module tgcw_cursor (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  tgcw_pkg::kind_t            kind,
  input  tgcw_pkg::key_class_t       cls,
  input  logic [tgcw_pkg::POS_W-1:0] pos_col,
  input  logic [tgcw_pkg::POS_W-1:0] pos_row,
  output logic [tgcw_pkg::POS_W-1:0] cursor_col,
  output logic [tgcw_pkg::POS_W-1:0] cursor_row
);

  logic [tgcw_pkg::POS_W-1:0] col_next;
  logic [tgcw_pkg::POS_W-1:0] row_next;
  logic [tgcw_pkg::POS_W-1:0] col_inc;
  logic [tgcw_pkg::POS_W-1:0] row_inc;

  assign col_inc = (cursor_col == tgcw_pkg::POS_MAX) ? cursor_col : cursor_col + 1'b1;
  assign row_inc = (cursor_row == tgcw_pkg::POS_MAX) ? cursor_row : cursor_row + 1'b1;

  always_comb begin
    col_next = cursor_col;
    row_next = cursor_row;
    unique case (kind)
      tgcw_pkg::KIND_KEY: begin
        unique case (cls)
          tgcw_pkg::KEY_NEWLINE: begin
            col_next = '0;
            row_next = row_inc;
          end
          tgcw_pkg::KEY_SPACE, tgcw_pkg::KEY_MARK, tgcw_pkg::KEY_PRINT: begin
            col_next = col_inc;
          end
          default: begin
          end
        endcase
      end
      tgcw_pkg::KIND_SET: begin
        col_next = pos_col;
        row_next = pos_row;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
    end else if (accept) begin
      cursor_col <= col_next;
      cursor_row <= row_next;
    end
  end

endmodule

// ----- sv/text_grid_cursor_writer_core.sv -----
// ----------------------------------------------------------------------------
// text_grid_cursor_writer_core
// Character-cell text buffer with a write cursor and a window-mapped store.
//
//   channel   dir  fields
//   s_*       in   tuser: kind; tdata: key_code, pos_col, pos_row
//   m_*       out  tdata: cursor_col, cursor_row, cell_written, cell_inside,
//                        cell_code, cell_marked
//   cfg_*     in   write: window_left, window_right, window_top, window_bottom
//
// Each item passes through accept, window test, memory access and result load.
// The window test and the memory read are both registered.
// After reset a clearing pass over all CELL_COUNT (8192) cells zeroes the store;
// s_tready stays low meanwhile, configuration writes are taken.
// A stalled result holds in m_tdata; the next item may be accepted meanwhile.
// ----------------------------------------------------------------------------
module text_grid_cursor_writer_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [31:0]                   s_tdata,  // key_code, pos_col, pos_row
  input  logic [1:0]                    s_tuser,  // kind
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // cursor_col, cursor_row, cell_written, cell_inside, cell_code, cell_marked
  output logic [39:0]                   m_tdata,
  input  logic                          cfg_we,
  input  logic [tgcw_pkg::RIDX_W-1:0]   cfg_index,
  input  logic [tgcw_pkg::REG_W-1:0]    cfg_data
);

  tgcw_pkg::ctl_state_t state;
  tgcw_pkg::ctl_state_t state_next;
  tgcw_pkg::window_t    win;
  tgcw_pkg::map_t       map;
  tgcw_pkg::mem_req_t   req;

  logic [tgcw_pkg::IDX_W-1:0]  clr_addr;
  logic [tgcw_pkg::IDX_W-1:0]  idx;
  logic [tgcw_pkg::POS_W-1:0]  cursor_col;
  logic [tgcw_pkg::POS_W-1:0]  cursor_row;
  logic [tgcw_pkg::CODE_W-1:0] rd_code;
  logic                        rd_mark;

  tgcw_pkg::kind_t      in_kind;
  tgcw_pkg::key_class_t in_cls;
  logic                 accept;
  logic                 out_load;
  logic                 clr_last;

  tgcw_pkg::kind_t             item_kind;
  tgcw_pkg::key_class_t        item_cls;
  logic [tgcw_pkg::CODE_W-1:0] item_code;
  logic [tgcw_pkg::POS_W-1:0]  item_col;
  logic [tgcw_pkg::POS_W-1:0]  item_row;
  logic                        res_written;
  logic                        res_inside;

  assign in_kind  = tgcw_pkg::kind_t'(s_tuser);
  assign in_cls   = tgcw_pkg::key_class(s_tdata[7:0]);
  assign s_tready = (state == tgcw_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign clr_last = (clr_addr == tgcw_pkg::IDX_W'(tgcw_pkg::CELL_COUNT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      win.left   <= tgcw_pkg::RESET_LEFT;
      win.right  <= tgcw_pkg::RESET_RIGHT;
      win.top    <= tgcw_pkg::RESET_TOP;
      win.bottom <= tgcw_pkg::RESET_BOTTOM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tgcw_pkg::REG_WINDOW_LEFT:   win.left   <= cfg_data;
        tgcw_pkg::REG_WINDOW_RIGHT:  win.right  <= cfg_data;
        tgcw_pkg::REG_WINDOW_TOP:    win.top    <= cfg_data;
        tgcw_pkg::REG_WINDOW_BOTTOM: win.bottom <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tgcw_cursor u_cursor (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .kind       (in_kind),
    .cls        (in_cls),
    .pos_col    (s_tdata[19:8]),
    .pos_row    (s_tdata[31:20]),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row)
  );

  // Hold the item; key items map at the cursor before it moves.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_kind <= in_kind;
      item_cls  <= in_cls;
      item_code <= s_tdata[7:0];
      if (in_kind == tgcw_pkg::KIND_KEY) begin
        item_col <= cursor_col;
        item_row <= cursor_row;
      end else begin
        item_col <= s_tdata[19:8];
        item_row <= s_tdata[31:20];
      end
    end
  end

  tgcw_cell_map u_map (
    .clk  (clk),
    .load (state == tgcw_pkg::ST_MAP),
    .win  (win),
    .col  (item_col),
    .row  (item_row),
    .map  (map),
    .idx  (idx)
  );

  always_comb begin
    req = '0;
    if (state == tgcw_pkg::ST_CLEAR) begin
      req.we_code = 1'b1;
      req.we_mark = 1'b1;
      req.addr    = clr_addr;
    end else if (state == tgcw_pkg::ST_ACCESS) begin
      req.addr    = idx;
      req.code    = item_code;
      req.mark    = 1'b1;
      req.we_code = map.in_window && (item_kind == tgcw_pkg::KIND_KEY) &&
                    (item_cls == tgcw_pkg::KEY_PRINT);
      req.we_mark = map.in_window && (item_kind == tgcw_pkg::KIND_KEY) &&
                    (item_cls == tgcw_pkg::KEY_MARK);
      req.rd      = map.in_window && (item_kind == tgcw_pkg::KIND_READ);
    end
  end

  tgcw_cell_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_code (rd_code),
    .rd_mark (rd_mark)
  );

  always_ff @(posedge clk) begin
    if (state == tgcw_pkg::ST_ACCESS) begin
      res_written <= req.we_code || req.we_mark;
      res_inside  <= req.rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == tgcw_pkg::ST_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tgcw_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    unique case (state)
      tgcw_pkg::ST_CLEAR: begin
        if (clr_last) state_next = tgcw_pkg::ST_IDLE;
      end
      tgcw_pkg::ST_IDLE: begin
        if (accept) state_next = tgcw_pkg::ST_MAP;
      end
      tgcw_pkg::ST_MAP: begin
        state_next = tgcw_pkg::ST_ACCESS;
      end
      tgcw_pkg::ST_ACCESS: begin
        state_next = tgcw_pkg::ST_DONE;
      end
      tgcw_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = tgcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tgcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata[11:0]  <= cursor_col;
      m_tdata[23:12] <= cursor_row;
      m_tdata[24]    <= res_written;
      m_tdata[25]    <= res_inside;
      m_tdata[33:26] <= res_inside ? rd_code : '0;
      m_tdata[34]    <= res_inside && rd_mark;
      m_tdata[39:35] <= '0;
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready ##1 !s_tready ##1 !s_tready)
    else $error("item accepted while previous item still in flight");

  a_write_inside: assert property (@(posedge clk) disable iff (rst)
    (state == tgcw_pkg::ST_ACCESS && (req.we_code || req.we_mark || req.rd))
      |-> map.in_window)
    else $error("cell access outside the window");

  a_one_access: assert property (@(posedge clk) disable iff (rst)
    (state == tgcw_pkg::ST_ACCESS) |-> $onehot0({req.we_code, req.we_mark, req.rd}))
    else $error("more than one cell access for one item");

  a_clear_then_idle: assert property (@(posedge clk) disable iff (rst)
    (state == tgcw_pkg::ST_CLEAR && clr_last) |=> (state == tgcw_pkg::ST_IDLE))
    else $error("clearing pass did not end at the last cell");
`endif

endmodule
